@@ hdl/etr_pkg.sv @@
// etr_pkg: shared types, constants and helpers for the event trace recorder.
// No dependencies; imported by the front, back and top-level modules of the block.
package etr_pkg;

  localparam int unsigned REC_CAP    = 32768;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned IDX_W      = 15;
  localparam int unsigned CH_COUNT   = 16;
  localparam int unsigned CH_W       = 4;
  localparam int unsigned LVL_W      = 8;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned TICK_SHIFT = 4;
  localparam int unsigned ETICK_W    = TIME_W - TICK_SHIFT;
  localparam int unsigned TICK_W     = 27;
  localparam int unsigned WIN_MS_W   = 22;
  localparam int unsigned US_PER_MS  = 1000;
  localparam int unsigned ADDR_W     = 2;
  localparam int unsigned QDEPTH     = 2;

  localparam logic [WIN_MS_W-1:0] WIN_MS_RESET = WIN_MS_W'(1000);
  localparam logic [TICK_W-1:0]   TICK_MAX     = {TICK_W{1'b1}};
  localparam logic [ADDR_W-1:0]   REG_WINDOW   = ADDR_W'(0);

  typedef enum logic [2:0] {
    OP_SET    = 3'd0,
    OP_TOGGLE = 3'd1,
    OP_START  = 3'd2,
    OP_STOP   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  // decoded item handed from front to back
  typedef struct packed {
    logic                is_set;
    logic                is_toggle;
    logic                is_start;
    logic                is_stop;
    logic                is_clear;
    logic                ch_ok;
    logic [CH_W-1:0]     channel;
    logic [LVL_W-1:0]    level;
    logic [TIME_W-1:0]   now_us;
  } item_t;

  typedef struct packed {
    logic                recorded;
    logic [IDX_W-1:0]    rec_index;
    logic [TICK_W-1:0]   rec_time;
    logic [CH_W-1:0]     rec_channel;
    logic [LVL_W-1:0]    rec_value;
    logic                full_res;
    logic                timed_out;
    logic                armed;
    logic [CH_COUNT-1:0] wide_channels;
  } res_t;

  // window in ms -> 16 us ticks, saturated
  function automatic logic [TICK_W-1:0] ms_to_ticks(input logic [WIN_MS_W-1:0] ms);
    logic [WIN_MS_W+9:0] us;
    logic [WIN_MS_W+9-TICK_SHIFT:0] t;
    begin
      us = ms * (WIN_MS_W+10)'(US_PER_MS);
      t  = us[WIN_MS_W+9:TICK_SHIFT];
      if (t > (WIN_MS_W+10-TICK_SHIFT)'(TICK_MAX)) begin
        ms_to_ticks = TICK_MAX;
      end else begin
        ms_to_ticks = t[TICK_W-1:0];
      end
    end
  endfunction

endpackage

@@ hdl/etr_front.sv @@
// etr_front: accepts input transfers, decodes the operation and queues the
// decoded item for the back end. Depends on etr_pkg.
module etr_front import etr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_op,
  input  logic [CH_W-1:0]     in_channel,
  input  logic [LVL_W-1:0]    in_level,
  input  logic [TIME_W-1:0]   in_now_us,
  output logic                q_valid,
  output item_t               q_item,
  input  logic                q_pop
);

  item_t            slot [QDEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  item_t            dec;
  logic             push;

  always_comb begin
    dec           = '0;
    dec.channel   = in_channel;
    dec.level     = in_level;
    dec.now_us    = in_now_us;
    dec.ch_ok     = (32'(in_channel) < CH_COUNT);
    case (in_op)
      OP_SET:    dec.is_set    = 1'b1;
      OP_TOGGLE: dec.is_toggle = 1'b1;
      OP_START:  dec.is_start  = 1'b1;
      OP_STOP:   dec.is_stop   = 1'b1;
      OP_CLEAR:  dec.is_clear  = 1'b1;
      default:   ;  // unknown codes only report status
    endcase
  end

  assign in_ready = (count < 2'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/etr_back.sv @@
// etr_back: executes decoded items against the capture state and holds the
// result in an output register. Depends on etr_pkg.
module etr_back import etr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  input  logic [TICK_W-1:0] win_cfg,
  output logic              out_valid,
  input  logic              out_ready,
  output res_t              out_res
);

  logic                capture_on, capture_on_next;
  logic [TIME_W-1:0]   start_time, start_time_next;
  logic [TICK_W-1:0]   window_ticks, window_ticks_next;
  logic [CNT_W-1:0]    entry_count, entry_count_next;
  logic [CH_COUNT-1:0] last_levels, last_levels_next;
  logic [CH_COUNT-1:0] wide_flags, wide_flags_next;
  res_t                res_next;

  logic [TIME_W-1:0]   diff;
  logic [ETICK_W-1:0]  elapsed;
  logic                hi_zero;
  logic                in_win;
  logic                below_win;
  logic                active;
  logic [CH_COUNT-1:0] mask;
  logic [LVL_W-1:0]    value;

  assign q_pop = q_valid && (!out_valid || out_ready);

  assign diff      = q_item.now_us - start_time;
  assign elapsed   = diff[TIME_W-1:TICK_SHIFT];
  assign hi_zero   = (elapsed[ETICK_W-1:TICK_W] == '0);
  assign in_win    = hi_zero && (elapsed[TICK_W-1:0] <= window_ticks);
  assign below_win = hi_zero && (elapsed[TICK_W-1:0] < window_ticks);
  assign mask      = CH_COUNT'(1) << q_item.channel;
  assign active    = (q_item.is_set || q_item.is_toggle) && capture_on && q_item.ch_ok
                     && (32'(entry_count) < REC_CAP);

  always_comb begin
    capture_on_next   = capture_on;
    start_time_next   = start_time;
    window_ticks_next = window_ticks;
    entry_count_next  = entry_count;
    last_levels_next  = last_levels;
    wide_flags_next   = wide_flags;
    res_next          = '0;
    value             = q_item.is_set ? q_item.level
                        : LVL_W'(((last_levels & mask) == '0) ? 1 : 0);

    if (active) begin
      if (in_win) begin
        res_next.recorded    = 1'b1;
        res_next.rec_index   = entry_count[IDX_W-1:0];
        res_next.rec_time    = elapsed[TICK_W-1:0];
        res_next.rec_channel = q_item.channel;
        res_next.rec_value   = value;
        entry_count_next     = entry_count + CNT_W'(1);
      end
      if (q_item.is_set) begin
        if (q_item.level > LVL_W'(1)) begin
          wide_flags_next = wide_flags | mask;
        end
        if (q_item.level != '0) begin
          last_levels_next = last_levels | mask;
        end else begin
          last_levels_next = last_levels & ~mask;
        end
      end else begin
        last_levels_next = last_levels ^ mask;
      end
    end

    if (q_item.is_start) begin
      entry_count_next  = '0;
      wide_flags_next   = '0;
      start_time_next   = q_item.now_us;
      capture_on_next   = 1'b1;
      window_ticks_next = win_cfg;
    end
    if (q_item.is_stop) begin
      capture_on_next = 1'b0;
    end
    if (q_item.is_clear) begin
      capture_on_next  = 1'b0;
      entry_count_next = '0;
      wide_flags_next  = '0;
    end

    res_next.full_res      = (32'(entry_count_next) == REC_CAP);
    res_next.armed         = capture_on_next;
    res_next.wide_channels = wide_flags_next;
    // a start makes elapsed zero, so it is timed out only for an empty window
    if (q_item.is_start) begin
      res_next.timed_out = (win_cfg == '0);
    end else begin
      res_next.timed_out = capture_on_next && !below_win;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_on   <= 1'b0;
      start_time   <= '0;
      window_ticks <= '0;
      entry_count  <= '0;
      last_levels  <= '0;
      wide_flags   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (q_pop) begin
        capture_on   <= capture_on_next;
        start_time   <= start_time_next;
        window_ticks <= window_ticks_next;
        entry_count  <= entry_count_next;
        last_levels  <= last_levels_next;
        wide_flags   <= wide_flags_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_res <= res_next;
    end
  end

endmodule

@@ hdl/event_trace_recorder.sv @@
// Event trace recorder top level: stream ports, APB config register, and
// the front (decode + 2-entry queue) and back (execute + output register).
// An input transfer passes through the queue, then the back end's output register.
// Throughput: one queued item retired per cycle by the back end, unless m_tready stalls it.
// Reset (rst, synchronous): capture disarmed, counters and flags cleared, queue
// and output register empty, window_ms back to 1000. No clearing pass.
module event_trace_recorder import etr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [63:0]       s_tdata,   // channel[3:0], level[11:4], now_us[59:12], zero pad
  input  logic [2:0]        s_tuser,   // operation[2:0]
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [79:0]       m_tdata,   // rec_index[14:0], rec_time[41:15],
                                       // rec_channel[45:42], rec_value[53:46],
                                       // full_res[54], timed_out[55], armed[56],
                                       // wide_channels[72:57], zero pad
  output logic [0:0]        m_tuser,   // recorded[0]
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [WIN_MS_W-1:0] window_ms;
  logic [TICK_W-1:0]   win_ticks;   // window_ms scaled to ticks at write time
  logic                cfg_wr;

  logic                q_valid;
  item_t               q_item;
  logic                q_pop;
  res_t                res;

  // ---------------------------------------------------------------------
  // Config: one register. The ms-to-tick multiply happens on the write so
  // the back end only copies the result at start.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_WINDOW);
  assign prdata = (paddr == REG_WINDOW) ? 32'(window_ms) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= WIN_MS_RESET;
      win_ticks <= ms_to_ticks(WIN_MS_RESET);
    end else if (cfg_wr) begin
      window_ms <= pwdata[WIN_MS_W-1:0];
      win_ticks <= ms_to_ticks(pwdata[WIN_MS_W-1:0]);
    end
  end

  // ---------------------------------------------------------------------
  // Front: decode and queue
  // ---------------------------------------------------------------------
  etr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_op      (s_tuser),
    .in_channel (s_tdata[3:0]),
    .in_level   (s_tdata[11:4]),
    .in_now_us  (s_tdata[59:12]),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // ---------------------------------------------------------------------
  // Back: execute against capture state, hold result until taken
  // ---------------------------------------------------------------------
  etr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .win_cfg   (win_ticks),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // result packing, lowest field first
  assign m_tuser = res.recorded;
  assign m_tdata = {7'd0, res.wide_channels, res.armed, res.timed_out, res.full_res,
                    res.rec_value, res.rec_channel, res.rec_time, res.rec_index};

endmodule

@@ hdl/etr_checker.sv @@
// etr_checker: port-level assertions for the event trace recorder, bound to
// the top level. Depends on event_trace_recorder ports only.
module etr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // no result appears right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // record fields are zero when nothing was recorded
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[53:0] == 54'd0)
    else $error("record fields set without a record");

  // timeout is reported only while armed
  a_timeout_armed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[55] |-> m_tdata[56])
    else $error("timed out while disarmed");

  // a record is only made while armed
  a_record_armed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[56])
    else $error("record while disarmed");

endmodule

bind event_trace_recorder etr_checker u_etr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ tb/sv/tb_event_trace_recorder.sv @@
// Self-checking testbench for event_trace_recorder: stream stimulus, stream
// checking against an in-bench predictor, and window register writes over APB.
// Depends on etr_pkg (operation codes, register address) and the recorder RTL.
`timescale 1ns / 1ps

module tb_event_trace_recorder;
  import etr_pkg::*;

  localparam int unsigned RECORD_CAP  = 32768;
  localparam int unsigned CHAN_COUNT  = 16;
  localparam int unsigned MS_TO_US    = 1000;
  localparam int unsigned TICK_SH     = 4;
  localparam logic [26:0] TICK_CEIL   = 27'h7FF_FFFF;
  localparam logic [21:0] WIN_MS_MAX  = 22'h3F_FFFF;
  localparam logic [21:0] WIN_MS_TOP  = 22'd2147483;
  localparam logic [21:0] WIN_MS_RST  = 22'd1000;
  // codes past clear: the block only reports status for these
  localparam logic [2:0]  OP_RSVD_LO  = 3'd5;
  localparam logic [2:0]  OP_RSVD_HI  = 3'd7;
  localparam int          SETTLE_CYC  = 6;
  localparam int          CYCLE_LIMIT = 400000;

  // one probe event as it goes onto the input stream
  typedef struct {
    logic [2:0]  op;
    logic [3:0]  channel;
    logic [7:0]  level;
    logic [47:0] now_us;
    logic        drain;   // hold this transfer back until all results are in
  } probe_ev_t;

  typedef struct packed {
    logic        recorded;
    logic [14:0] rec_index;
    logic [26:0] rec_time;
    logic [3:0]  rec_channel;
    logic [7:0]  rec_value;
    logic        full_res;
    logic        timed_out;
    logic        armed;
    logic [15:0] wide_channels;
  } trace_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [0:0]  m_tuser;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  event_trace_recorder dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  probe_ev_t  event_q[$];     // events waiting to be driven
  trace_rec_t record_q[$];    // predicted results, oldest first
  probe_ev_t  drv_ev;         // event currently on the input bus
  trace_rec_t got_rec;
  trace_rec_t want_rec;
  int         errors = 0;
  int         cycles = 0;
  int         send_idle = 0;  // percent of cycles the sender holds off
  int         rcv_idle = 0;   // percent of cycles the receiver stalls

  // Predictor state: mirrors the recorder's registers
  logic        trace_on = 1'b0;
  logic [47:0] trace_t0 = '0;
  logic [26:0] trace_wt = '0;
  int unsigned trace_count = 0;
  logic [15:0] trace_levels = '0;
  logic [15:0] trace_wide = '0;
  logic [21:0] cfg_window_ms = WIN_MS_RST;

  // Stimulus side view of the capture timing, used to aim event times
  logic [47:0] gen_start = '0;
  logic [26:0] gen_wt;

  // window in ms -> 16 us ticks, saturated to the 27-bit tick range
  function automatic logic [26:0] window_ticks(logic [21:0] ms);
    longint unsigned w;
    w = (64'(ms) * MS_TO_US) >> TICK_SH;
    return (w > 64'(TICK_CEIL)) ? TICK_CEIL : 27'(w);
  endfunction

  // elapsed 16 us ticks since the latched start; 48-bit wrapping difference
  function automatic logic [43:0] elapsed_ticks(logic [47:0] now);
    logic [47:0] diff;
    diff = now - trace_t0;
    return diff[47:TICK_SH];
  endfunction

  // Apply one event to the predictor state and return the expected result.
  function automatic trace_rec_t trace_predict(probe_ev_t ev);
    trace_rec_t r;
    logic [43:0] el;
    logic [15:0] bitm;
    logic [7:0]  v;
    r = '0;
    bitm = 16'(1) << ev.channel;
    if (ev.op == OP_SET || ev.op == OP_TOGGLE) begin
      // disarmed, full or bad channel: nothing changes, not even the levels
      if (trace_on && 32'(ev.channel) < CHAN_COUNT && trace_count < RECORD_CAP) begin
        el = elapsed_ticks(ev.now_us);
        if (ev.op == OP_SET) begin
          v = ev.level;
        end else begin
          v = ((trace_levels & bitm) != 0) ? 8'd0 : 8'd1;
        end
        if (el <= 44'(trace_wt)) begin
          r.recorded    = 1'b1;
          r.rec_index   = 15'(trace_count);
          r.rec_time    = 27'(el);
          r.rec_channel = ev.channel;
          r.rec_value   = v;
          trace_count++;
        end
        // levels and wide flags move even when the event lands past the window
        if (ev.op == OP_SET) begin
          if (ev.level > 8'd1) trace_wide = trace_wide | bitm;
          if (ev.level != 8'd0) trace_levels = trace_levels | bitm;
          else trace_levels = trace_levels & ~bitm;
        end else begin
          trace_levels = trace_levels ^ bitm;
        end
      end
    end else if (ev.op == OP_START) begin
      // start keeps the last levels
      trace_count = 0;
      trace_wide  = '0;
      trace_t0    = ev.now_us;
      trace_on    = 1'b1;
      trace_wt    = window_ticks(cfg_window_ms);
    end else if (ev.op == OP_STOP) begin
      trace_on = 1'b0;
    end else if (ev.op == OP_CLEAR) begin
      trace_on    = 1'b0;
      trace_count = 0;
      trace_wide  = '0;
    end
    el = elapsed_ticks(ev.now_us);
    r.full_res      = (trace_count == RECORD_CAP);
    r.timed_out     = trace_on && (el >= 44'(trace_wt));
    r.armed         = trace_on;
    r.wide_channels = trace_wide;
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Input driver: a new transfer goes out once the bus is free; prediction is
  // made at the edge where the transfer is accepted.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        record_q.push_back(trace_predict(drv_ev));
      end
      if (event_q.size() != 0 && !(event_q[0].drain && record_q.size() != 0) &&
          $urandom_range(99) >= send_idle) begin
        drv_ev = event_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, drv_ev.now_us, drv_ev.level, drv_ev.channel};
        s_tuser  <= drv_ev.op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_rec.recorded      = m_tuser[0];
        got_rec.rec_index     = m_tdata[14:0];
        got_rec.rec_time      = m_tdata[41:15];
        got_rec.rec_channel   = m_tdata[45:42];
        got_rec.rec_value     = m_tdata[53:46];
        got_rec.full_res      = m_tdata[54];
        got_rec.timed_out     = m_tdata[55];
        got_rec.armed         = m_tdata[56];
        got_rec.wide_channels = m_tdata[72:57];
        if (record_q.size() == 0) begin
          $error("result transfer with no expectation pending");
          errors++;
        end else begin
          want_rec = record_q.pop_front();
          check_field("recorded", want_rec.recorded, got_rec.recorded);
          check_field("rec_index", want_rec.rec_index, got_rec.rec_index);
          check_field("rec_time", want_rec.rec_time, got_rec.rec_time);
          check_field("rec_channel", want_rec.rec_channel, got_rec.rec_channel);
          check_field("rec_value", want_rec.rec_value, got_rec.rec_value);
          check_field("full_res", want_rec.full_res, got_rec.full_res);
          check_field("timed_out", want_rec.timed_out, got_rec.timed_out);
          check_field("armed", want_rec.armed, got_rec.armed);
          check_field("wide_channels", want_rec.wide_channels, got_rec.wide_channels);
        end
      end
      m_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic add_ev(input logic [2:0] op, input logic [3:0] ch, input logic [7:0] lvl,
                        input logic [47:0] now, input logic drain = 1'b0);
    probe_ev_t ev;
    ev.op = op;
    ev.channel = ch;
    ev.level = lvl;
    ev.now_us = now;
    ev.drain = drain;
    if (op == OP_START) gen_start = now;
    event_q.push_back(ev);
  endtask

  // Event time aimed around the current capture: start, window edge, just
  // past it, slightly before start (wraps), anywhere, or within or just past the window.
  function automatic logic [47:0] pick_now();
    logic [47:0] edge_us;
    edge_us = gen_start + (48'(gen_wt) << TICK_SH);
    case ($urandom_range(9))
      0: return gen_start;
      1: return edge_us + 48'($urandom_range(15));
      2: return edge_us + 48'(16 + $urandom_range(15));
      3: return gen_start - 48'($urandom_range(1, 4096));
      4: return 48'({$urandom, $urandom});
      default: return gen_start + 48'($urandom_range(0, (32'(gen_wt) << TICK_SH) + 64));
    endcase
  endfunction

  function automatic logic [7:0] pick_level();
    if ($urandom_range(1) != 0) return 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly armed set/toggle traffic with occasional restarts and noise.
  task automatic add_random_events(input int count);
    int sel;
    logic [47:0] t;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        if ($urandom_range(3) == 0) t = 48'({$urandom, $urandom});
        else t = gen_start + 48'($urandom_range(0, 100000));
        add_ev(OP_START, 4'($urandom), 8'($urandom), t);
      end else if (sel < 11) begin
        add_ev(OP_STOP, 4'($urandom), 8'($urandom), pick_now());
      end else if (sel < 14) begin
        add_ev(OP_CLEAR, 4'($urandom), 8'($urandom), pick_now());
      end else if (sel < 16) begin
        add_ev(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), 4'($urandom), 8'($urandom),
               pick_now());
      end else if (sel < 58) begin
        add_ev(OP_SET, 4'($urandom), pick_level(), pick_now());
      end else begin
        add_ev(OP_TOGGLE, 4'($urandom), 8'($urandom), pick_now());
      end
    end
  endtask

  // Wait until every event is accepted and every result is in, then let the
  // pipeline settle.
  task automatic wait_quiet();
    while (event_q.size() != 0 || s_tvalid || record_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // APB write of the window register, then a read back of it
  task automatic write_window(input logic [21:0] ms);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_WINDOW;
    pwdata  <= 32'(ms);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    cfg_window_ms = ms;
    gen_wt = window_ticks(ms);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(ms)) begin
      $error("window_ms readback: expected %0d, got %0d", ms, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [47:0] s0;
    gen_wt = window_ticks(WIN_MS_RST);
    send_idle = 32;
    rcv_idle  = 59;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset window of 1000 ms
    add_ev(OP_SET, 4'd0, 8'd5, 48'd0);                 // disarmed: no effect
    add_ev(OP_TOGGLE, 4'd15, 8'd0, 48'd0);
    add_ev(OP_RSVD_HI, 4'd3, 8'd9, 48'd0);             // unknown code
    s0 = 48'hFFFF_FFFF_FF00;                           // start just before wrap
    add_ev(OP_START, 4'd0, 8'd0, s0);
    add_ev(OP_SET, 4'd0, 8'd0, s0);                    // tick zero, level zero
    add_ev(OP_SET, 4'd15, 8'd255, s0 + 48'h200);       // time wraps through zero
    add_ev(OP_SET, 4'd3, 8'd1, s0 + 48'h300);          // single-bit level
    add_ev(OP_SET, 4'd4, 8'd2, s0 + 48'h400);          // wide
    add_ev(OP_TOGGLE, 4'd3, 8'd0, s0 + 48'h500);       // was high: records 0
    add_ev(OP_TOGGLE, 4'd5, 8'd0, s0 + 48'h600);
    add_ev(OP_TOGGLE, 4'd5, 8'd0, s0 + 48'h700);
    // last tick inside the window, then first tick past it
    add_ev(OP_SET, 4'd6, 8'd1, s0 + (48'(gen_wt) << TICK_SH) + 48'd15);
    add_ev(OP_SET, 4'd7, 8'd1, s0 + (48'(gen_wt + 1) << TICK_SH));
    add_ev(OP_TOGGLE, 4'd7, 8'd0, s0 + 48'h800);       // sees level from late set
    add_ev(OP_SET, 4'd8, 8'd3, s0 - 48'd1);            // time running backwards
    add_ev(OP_STOP, 4'd0, 8'd0, s0 + 48'h900);
    add_ev(OP_SET, 4'd9, 8'd7, s0 + 48'h900);          // disarmed
    add_ev(OP_TOGGLE, 4'd4, 8'd0, s0 + 48'h900);       // disarmed: level kept
    add_ev(OP_START, 4'd0, 8'd0, 48'h0000_0000_1234);  // levels survive restart
    add_ev(OP_TOGGLE, 4'd4, 8'd0, 48'h0000_0000_1234);
    add_ev(OP_CLEAR, 4'd0, 8'd0, 48'h0000_0000_1240);
    add_ev(OP_RSVD_LO, 4'd1, 8'd1, 48'hFFFF_FFFF_FFFF);
    wait_quiet();

    // Random part, sender 32 / receiver 59 idle
    write_window(22'd1);
    add_random_events(150);
    add_ev(OP_SET, 4'($urandom), pick_level(), pick_now(), 1'b1);  // pause for drain
    add_random_events(150);
    wait_quiet();
    write_window(22'd0);
    add_random_events(100);
    wait_quiet();

    // Swap the idle shares
    send_idle = 59;
    rcv_idle  = 32;
    write_window(22'd2);
    add_random_events(300);
    wait_quiet();
    write_window(WIN_MS_TOP);
    add_random_events(100);
    wait_quiet();

    // No idling; saturated window, then a short 5 ms window
    send_idle = 0;
    rcv_idle  = 0;
    write_window(WIN_MS_MAX);
    add_random_events(150);
    wait_quiet();
    write_window(22'd5);
    add_ev(OP_START, 4'd0, 8'd0, 48'({$urandom, $urandom}));
    for (int i = 0; i < 30; i++) begin
      add_ev(($urandom_range(1) != 0) ? OP_SET : OP_TOGGLE, 4'($urandom), pick_level(),
             gen_start + 48'($urandom_range(0, 6000)));
    end
    // near the window start, then in the last tick of the window
    add_ev(OP_SET, 4'd2, 8'd200, gen_start + 48'd16);
    add_ev(OP_TOGGLE, 4'd2, 8'd0, gen_start + 48'd32);
    add_ev(OP_SET, 4'd2, 8'd0, gen_start + 48'd5000);
    add_ev(OP_STOP, 4'd0, 8'd0, gen_start);
    add_random_events(100);
    wait_quiet();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/etr_pkg.sv
hdl/etr_front.sv
hdl/etr_back.sv
hdl/event_trace_recorder.sv
hdl/etr_checker.sv
tb/sv/tb_event_trace_recorder.sv
